>>> sv/border_pad_coordinate_map_macros.svh
// assertion macros for the border pad coordinate map
`ifndef BORDER_PAD_COORDINATE_MAP_MACROS_SVH
`define BORDER_PAD_COORDINATE_MAP_MACROS_SVH

// same-cycle implication, disabled during reset
`define BPCM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bpcm same-cycle check failed");

// next-cycle implication, disabled during reset
`define BPCM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bpcm next-cycle check failed");

`endif

>>> sv/bpcm_pkg.sv
// shared widths, register indexes and stage types for the border pad coordinate map
package bpcm_pkg;

    localparam int MAX_DIM = 4096;
    localparam int MAX_PAD = 4095;

    localparam int DIM_W  = 13;                 // image size registers
    localparam int PAD_W  = 12;                 // pad registers
    localparam int POS_W  = 14;                 // padded coordinates
    localparam int SRC_W  = 12;                 // source coordinates
    localparam int CFG_W  = 13;                 // widest register
    localparam int IDX_W  = 3;                  // register index
    localparam int CELLS  = SRC_W;              // one restoring step per remainder bit
    localparam int DIV_W  = DIM_W + CELLS - 1;  // size shifted to the top step

    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] REG_PAD_LEFT     = 3'd2;
    localparam logic [IDX_W-1:0] REG_PAD_RIGHT    = 3'd3;
    localparam logic [IDX_W-1:0] REG_PAD_TOP      = 3'd4;
    localparam logic [IDX_W-1:0] REG_PAD_BOTTOM   = 3'd5;
    localparam logic [IDX_W-1:0] REG_EDGE_MODE    = 3'd6;

    // one axis on its way through the modulo chain
    typedef struct packed {
        logic [SRC_W-1:0] rem;   // partial remainder
        logic [DIV_W-1:0] div;   // divisor aligned to the current step
        logic             neg;   // fold the final remainder up from size
    } axis_t;

    typedef struct packed {
        logic  bad;
        axis_t col;
        axis_t row;
    } item_t;

    // valid and ready between neighboring stages
    typedef struct packed {
        logic valid;
        logic ready;
    } hs_t;

endpackage

>>> sv/bpcm_axis_map.sv
// per-axis front end: folds a padded index into a value for the modulo chain
module bpcm_axis_map (
    input  logic [bpcm_pkg::POS_W-1:0] pos,
    input  logic [bpcm_pkg::PAD_W-1:0] lead,
    input  logic [bpcm_pkg::DIM_W-1:0] size,
    input  logic [bpcm_pkg::PAD_W-1:0] after,
    input  logic                       mirror,
    output bpcm_pkg::axis_t            axis,
    output logic                       bad
);

    logic [bpcm_pkg::POS_W:0]   extent;
    logic [bpcm_pkg::POS_W-1:0] off;
    logic [bpcm_pkg::POS_W-1:0] q2;
    logic [bpcm_pkg::POS_W-1:0] v;
    logic                       neg;

    always_comb begin
        extent = (bpcm_pkg::POS_W+1)'(lead) + (bpcm_pkg::POS_W+1)'(size)
               + (bpcm_pkg::POS_W+1)'(after);
        bad    = {1'b0, pos} >= extent;
        off    = pos - bpcm_pkg::POS_W'(lead);
        q2     = off - bpcm_pkg::POS_W'(size) + bpcm_pkg::POS_W'(2);
        neg    = 1'b0;
        if (pos < bpcm_pkg::POS_W'(lead)) begin
            v = mirror ? (bpcm_pkg::POS_W'(lead) - pos) : '0;
        end else if (off < bpcm_pkg::POS_W'(size)) begin
            v = off;
        end else if (!mirror) begin
            v = bpcm_pkg::POS_W'(size) - bpcm_pkg::POS_W'(1);
        end else if (q2 <= bpcm_pkg::POS_W'(size)) begin
            v = bpcm_pkg::POS_W'(size) - q2;
        end else begin
            // negative reflection: keep the magnitude, fold up at the end
            v   = q2 - bpcm_pkg::POS_W'(size);
            neg = 1'b1;
        end
        axis.rem = v[bpcm_pkg::SRC_W-1:0];
        axis.div = {size, {(bpcm_pkg::CELLS-1){1'b0}}};
        axis.neg = neg;
    end

endmodule

>>> sv/bpcm_cell.sv
// one restoring modulo step for both axes, registered with its own handshake
module bpcm_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    input  bpcm_pkg::item_t in_item,
    output logic            in_ready,
    output logic            out_valid,
    output bpcm_pkg::item_t out_item,
    input  logic            out_ready
);

    logic            valid_reg;
    bpcm_pkg::item_t item_reg;
    bpcm_pkg::item_t item_next;

    function automatic bpcm_pkg::axis_t step(input bpcm_pkg::axis_t a);
        bpcm_pkg::axis_t r;
        r = a;
        if (bpcm_pkg::DIV_W'(a.rem) >= a.div) begin
            r.rem = a.rem - a.div[bpcm_pkg::SRC_W-1:0];
        end
        r.div = a.div >> 1;
        return r;
    endfunction

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb begin
        item_next     = in_item;
        item_next.col = step(in_item.col);
        item_next.row = step(in_item.row);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

endmodule

>>> sv/border_pad_coordinate_map.sv
// top level of the border pad coordinate map: config, front stage, cell chain, output stage
//
//  channel   direction  signals                          moves
//  s_        in         s_valid s_ready s_out_col/row    one padded position per request
//  m_        out        m_valid m_ready m_src_col/row    one source position per request
//  cfg_      in         cfg_wr_en cfg_index cfg_wdata    one register write per cycle
//
//  throughput one request per cycle unless m_ready stalls the output; a request passes the
//  front stage, 12 modulo cells (a restoring step per source-coordinate bit), output stage
//  every stage has its own valid and a local ready, so bubbles close up under stalls
//  and a new request is taken while a finished result waits at the output
//  reset (aresetn low, synchronous) empties all stages and loads the register defaults
module border_pad_coordinate_map (
    input  logic                          aclk,
    input  logic                          aresetn,
    // configuration
    input  logic                          cfg_wr_en,
    input  logic [bpcm_pkg::IDX_W-1:0]    cfg_index,
    input  logic [bpcm_pkg::CFG_W-1:0]    cfg_wdata,
    // input requests
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [bpcm_pkg::POS_W-1:0]    s_out_col,
    input  logic [bpcm_pkg::POS_W-1:0]    s_out_row,
    // result requests
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [bpcm_pkg::SRC_W-1:0]    m_src_col,
    output logic [bpcm_pkg::SRC_W-1:0]    m_src_row,
    output logic                          m_out_of_range
);

    `include "border_pad_coordinate_map_macros.svh"

    // configuration registers
    logic [bpcm_pkg::DIM_W-1:0] image_width_reg;
    logic [bpcm_pkg::DIM_W-1:0] image_height_reg;
    logic [bpcm_pkg::PAD_W-1:0] pad_left_reg;
    logic [bpcm_pkg::PAD_W-1:0] pad_right_reg;
    logic [bpcm_pkg::PAD_W-1:0] pad_top_reg;
    logic [bpcm_pkg::PAD_W-1:0] pad_bottom_reg;
    logic                       edge_mode_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= bpcm_pkg::DIM_W'(1);
            image_height_reg <= bpcm_pkg::DIM_W'(1);
            pad_left_reg     <= '0;
            pad_right_reg    <= '0;
            pad_top_reg      <= '0;
            pad_bottom_reg   <= '0;
            edge_mode_reg    <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bpcm_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= cfg_wdata;
                bpcm_pkg::REG_IMAGE_HEIGHT: image_height_reg <= cfg_wdata;
                bpcm_pkg::REG_PAD_LEFT:     pad_left_reg     <= cfg_wdata[bpcm_pkg::PAD_W-1:0];
                bpcm_pkg::REG_PAD_RIGHT:    pad_right_reg    <= cfg_wdata[bpcm_pkg::PAD_W-1:0];
                bpcm_pkg::REG_PAD_TOP:      pad_top_reg      <= cfg_wdata[bpcm_pkg::PAD_W-1:0];
                bpcm_pkg::REG_PAD_BOTTOM:   pad_bottom_reg   <= cfg_wdata[bpcm_pkg::PAD_W-1:0];
                bpcm_pkg::REG_EDGE_MODE:    edge_mode_reg    <= cfg_wdata[0];
                default: ;  // unused index, write dropped
            endcase
        end
    end

    // sizes of zero count as one, sizes past the limit saturate
    // (pads are 12 bits and so can never exceed the pad limit)
    function automatic logic [bpcm_pkg::DIM_W-1:0] clamp_size(
        input logic [bpcm_pkg::DIM_W-1:0] s
    );
        logic [bpcm_pkg::DIM_W-1:0] r;
        r = s;
        if (s == '0) begin
            r = bpcm_pkg::DIM_W'(1);
        end else if (s > bpcm_pkg::DIM_W'(bpcm_pkg::MAX_DIM)) begin
            r = bpcm_pkg::DIM_W'(bpcm_pkg::MAX_DIM);
        end
        return r;
    endfunction

    logic [bpcm_pkg::DIM_W-1:0] width_eff;
    logic [bpcm_pkg::DIM_W-1:0] height_eff;

    assign width_eff  = clamp_size(image_width_reg);
    assign height_eff = clamp_size(image_height_reg);

    // front stage: per-axis fold straight from the request ports
    bpcm_pkg::axis_t col_front;
    bpcm_pkg::axis_t row_front;
    logic            col_bad;
    logic            row_bad;

    bpcm_axis_map u_map_col (
        .pos    (s_out_col),
        .lead   (pad_left_reg),
        .size   (width_eff),
        .after  (pad_right_reg),
        .mirror (edge_mode_reg),
        .axis   (col_front),
        .bad    (col_bad)
    );

    bpcm_axis_map u_map_row (
        .pos    (s_out_row),
        .lead   (pad_top_reg),
        .size   (height_eff),
        .after  (pad_bottom_reg),
        .mirror (edge_mode_reg),
        .axis   (row_front),
        .bad    (row_bad)
    );

    logic            st0_valid_reg;
    bpcm_pkg::item_t st0_item_reg;
    bpcm_pkg::hs_t   chain_hs [bpcm_pkg::CELLS+1];
    bpcm_pkg::item_t chain_item [bpcm_pkg::CELLS+1];

    assign s_ready          = !st0_valid_reg || chain_hs[0].ready;
    assign chain_hs[0].valid = st0_valid_reg;
    assign chain_item[0]     = st0_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st0_valid_reg <= 1'b0;
        end else if (s_ready) begin
            st0_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            st0_item_reg.bad <= col_bad || row_bad;
            st0_item_reg.col <= col_front;
            st0_item_reg.row <= row_front;
        end
    end

    // modulo chain: each cell takes one quotient bit off both remainders
    for (genvar i = 0; i < bpcm_pkg::CELLS; i++) begin : g_cell
        bpcm_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_hs[i].valid),
            .in_item   (chain_item[i]),
            .in_ready  (chain_hs[i].ready),
            .out_valid (chain_hs[i+1].valid),
            .out_item  (chain_item[i+1]),
            .out_ready (chain_hs[i+1].ready)
        );
    end

    // output stage: undo the negative fold and zero out-of-range results
    logic                       out_valid_reg;
    logic [bpcm_pkg::SRC_W-1:0] src_col_reg;
    logic [bpcm_pkg::SRC_W-1:0] src_row_reg;
    logic                       out_of_range_reg;
    logic [bpcm_pkg::SRC_W-1:0] src_col_next;
    logic [bpcm_pkg::SRC_W-1:0] src_row_next;
    bpcm_pkg::item_t            tail;

    function automatic logic [bpcm_pkg::SRC_W-1:0] finish(
        input bpcm_pkg::axis_t            a,
        input logic [bpcm_pkg::DIM_W-1:0] size
    );
        logic [bpcm_pkg::SRC_W-1:0] r;
        r = a.rem;
        if (a.neg && a.rem != '0) begin
            r = bpcm_pkg::SRC_W'(size - bpcm_pkg::DIM_W'(a.rem));
        end
        return r;
    endfunction

    assign tail                          = chain_item[bpcm_pkg::CELLS];
    assign chain_hs[bpcm_pkg::CELLS].ready = !out_valid_reg || m_ready;

    always_comb begin
        src_col_next = tail.bad ? '0 : finish(tail.col, width_eff);
        src_row_next = tail.bad ? '0 : finish(tail.row, height_eff);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (chain_hs[bpcm_pkg::CELLS].ready) begin
            out_valid_reg <= chain_hs[bpcm_pkg::CELLS].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (chain_hs[bpcm_pkg::CELLS].ready && chain_hs[bpcm_pkg::CELLS].valid) begin
            src_col_reg      <= src_col_next;
            src_row_reg      <= src_row_next;
            out_of_range_reg <= tail.bad;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_src_col      = src_col_reg;
    assign m_src_row      = src_row_reg;
    assign m_out_of_range = out_of_range_reg;

    // an out-of-range result carries zero coordinates
    `BPCM_ASSERT_IMPLY(a_bad_zero, aclk, aresetn, m_valid && m_out_of_range,
        m_src_col == '0 && m_src_row == '0)
    // an in-range result always lands inside the source image
    `BPCM_ASSERT_IMPLY(a_in_image, aclk, aresetn, m_valid && !m_out_of_range,
        bpcm_pkg::DIM_W'(m_src_col) < width_eff && bpcm_pkg::DIM_W'(m_src_row) < height_eff)
    // the negative fold only arises in mirror mode
    `BPCM_ASSERT_IMPLY(a_neg_mirror, aclk, aresetn,
        st0_valid_reg && (st0_item_reg.col.neg || st0_item_reg.row.neg), edge_mode_reg)
    // an accepted request always occupies the front stage next cycle
    `BPCM_ASSERT_NEXT(a_front_fill, aclk, aresetn, s_valid && s_ready, st0_valid_reg)

endmodule
